// ===== rtl/core/mie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    localparam int DEFAULT_WIDTH = 63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;         // take a new item into the Euclid registers
        logic div_start;    // set up remainder, divisor and accumulator
        logic align_shift;  // double the divisor
        logic div_step;     // one restoring step, one quotient bit
        logic update;       // rotate (a, b) and (s, u)
        logic out_load;     // reduce s and write the result register
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic align_more;
        logic k_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/mie_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire mie_pkg::t_status i_status,
    output mie_pkg::t_cmd        o_cmd
);

    mie_pkg::t_state r_state;
    mie_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mie_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mie_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mie_pkg::ST_CHECK;
                end
            end
            mie_pkg::ST_CHECK: begin
                if (i_status.b_zero) begin
                    n_state = mie_pkg::ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = mie_pkg::ST_ALIGN;
                end
            end
            mie_pkg::ST_ALIGN: begin
                if (i_status.align_more) begin
                    o_cmd.align_shift = 1'b1;
                end else begin
                    n_state = mie_pkg::ST_DIVIDE;
                end
            end
            mie_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.k_zero) begin
                    n_state = mie_pkg::ST_UPDATE;
                end
            end
            mie_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = mie_pkg::ST_CHECK;
            end
            mie_pkg::ST_FINISH: begin
                // hold the finished item until the result register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mie_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mie_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mie_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mie_dp #(
    parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [WIDTH-1:0] i_cfg_modulus,
    input  wire logic [WIDTH-1:0] i_value,
    input  wire mie_pkg::t_cmd    i_cmd,
    output mie_pkg::t_status      o_status,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [WIDTH-1:0]      o_inverse,
    output logic [WIDTH-1:0]      o_common_divisor
);

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_a, r_b, r_rem, r_d;
    logic [WIDTH:0]   r_s, r_u, r_acc;
    logic [KW-1:0]    r_k;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_inverse, r_gcd;

    logic [WIDTH-1:0] n_a, n_b, n_rem, n_d;
    logic [WIDTH:0]   n_s, n_u, n_acc;
    logic [KW-1:0]    n_k;
    logic             n_out_valid;
    logic [WIDTH-1:0] n_inverse, n_gcd;

    logic             ge;
    logic [WIDTH:0]   wrap_sum;
    logic [WIDTH-1:0] reduced;

    assign ge       = (r_rem >= r_d);
    // s lies in [-m, m]; one add or one compare brings it into [0, m-1]
    assign wrap_sum = r_s + {1'b0, r_mod};

    always_comb begin
        if (r_mod == '0) begin
            reduced = '0;
        end else if (r_s[WIDTH]) begin
            reduced = wrap_sum[WIDTH-1:0];
        end else if (r_s == {1'b0, r_mod}) begin
            reduced = '0;
        end else begin
            reduced = r_s[WIDTH-1:0];
        end
    end

    assign o_status.b_zero     = (r_b == '0);
    assign o_status.align_more = ({r_d, 1'b0} <= {1'b0, r_rem});
    assign o_status.k_zero     = (r_k == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_a         = r_a;
        n_b         = r_b;
        n_s         = r_s;
        n_u         = r_u;
        n_rem       = r_rem;
        n_d         = r_d;
        n_acc       = r_acc;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_inverse   = r_inverse;
        n_gcd       = r_gcd;
        if (i_cmd.load) begin
            n_a = i_value;
            n_b = r_mod;
            n_s = {{WIDTH{1'b0}}, 1'b1};
            n_u = '0;
        end
        if (i_cmd.div_start) begin
            n_rem = r_a;
            n_d   = r_b;
            n_acc = '0;
            n_k   = '0;
        end
        if (i_cmd.align_shift) begin
            n_d = {r_d[WIDTH-2:0], 1'b0};
            n_k = r_k + 1'b1;
        end
        if (i_cmd.div_step) begin
            // quotient bits come MSB first; q*u builds up alongside, mod 2^(WIDTH+1)
            n_rem = ge ? (r_rem - r_d) : r_rem;
            n_acc = {r_acc[WIDTH-1:0], 1'b0} + (ge ? r_u : '0);
            n_d   = {1'b0, r_d[WIDTH-1:1]};
            n_k   = r_k - 1'b1;
        end
        if (i_cmd.update) begin
            n_a = r_b;
            n_b = r_rem;
            n_s = r_u;
            n_u = r_s - r_acc;
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_inverse   = reduced;
            n_gcd       = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= {{(WIDTH-1){1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= i_cfg_modulus;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_s       <= n_s;
        r_u       <= n_u;
        r_rem     <= n_rem;
        r_d       <= n_d;
        r_acc     <= n_acc;
        r_k       <= n_k;
        r_inverse <= n_inverse;
        r_gcd     <= n_gcd;
    end

    assign o_out_valid      = r_out_valid;
    assign o_inverse        = r_inverse;
    assign o_common_divisor = r_gcd;

endmodule

`default_nettype wire

// ===== rtl/core/modular_inverse_ext_euclid_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_ready    i_value
// out       source     o_out_valid / i_out_ready  o_inverse, o_common_divisor
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_modulus
//
// One item at a time. Each Euclid step, with k = floor(log2(quotient)), runs one check state,
// k divisor doublings and a last visit to the align state that leaves the loop,
// k+1 restoring steps, and one update state.
// Reset is synchronous, active low; it sets the modulus to 1 and empties the result register.
// The result register frees the core: a new item is taken while a result waits,
// and a finished item waits only if the previous result is still not taken.
module modular_inverse_ext_euclid_top #(
    parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [WIDTH-1:0] i_cfg_modulus,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [WIDTH-1:0] i_value,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [WIDTH-1:0]      o_inverse,
    output logic [WIDTH-1:0]      o_common_divisor
);

    mie_pkg::t_cmd    cmd;
    mie_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mie_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_modulus    (i_cfg_modulus),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_inverse        (o_inverse),
        .o_common_divisor (o_common_divisor)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mie_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mie_checker #(
    parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [WIDTH-1:0] o_inverse,
    input wire logic [WIDTH-1:0] o_common_divisor
);

    logic       in_acc, out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // items taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_inverse) && $stable(o_common_divisor)))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready again in the cycle after an item was taken");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 2'd0))
        else $error("result shown with no item outstanding");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_pending == 2'd0 || r_pending == 2'd1))
        else $error("item taken while two are already outstanding");

endmodule

bind modular_inverse_ext_euclid_top mie_checker #(.WIDTH(WIDTH)) u_mie_checker (.*);

`default_nettype wire
